>>> rtl/tfc_pkg.sv
package tfc_pkg;

  // Queue size and derived widths.
  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Field widths.
  localparam int TAG_W  = 16;
  localparam int PAY_W  = 32;
  localparam int HND_W  = 16;
  localparam int PE_W   = 16;
  localparam int LOAD_W = 5;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;

  // Stream payload widths, padded to whole bytes.
  localparam int S_DATA_W = 80;
  localparam int M_DATA_W = 88;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PICK   = 2'd2
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // One queue entry.
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [PAY_W-1:0] payload;
    logic [HND_W-1:0] handle;
  } entry_t;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic             add_en;
    logic             pick_en;
    logic             rm_en;
    logic [CNT_W-1:0] count;
    logic [TAG_W-1:0] key;
    entry_t           new_entry;
  } cell_ctl_t;

endpackage

>>> rtl/tagged_fifo_with_cancel_top.sv
// Tagged work queue with cancel by tag.
// Input channel s_*: one item is an operation. s_tuser carries the op code
// (add, remove by tag, pick oldest); s_tdata carries the payload, send
// handle, key and destination fields. Output channel m_*: exactly one result
// item per input item, in order, with the status in m_tuser and the tag,
// payload, handle, destination and load in m_tdata.
// The queue is a row of cells, oldest entry in cell 0. Every cell compares
// its tag with the key at once, and a hit chain through the row marks the
// oldest match; cells at and after it take their neighbor's entry, so the
// queue closes up in the same cycle.
// The result is registered into the output register on acceptance. An item
// is taken every cycle while the result register is empty or being drained,
// so throughput is one item per cycle; the row's hit chain bounds the clock.
// When the receiver stalls, the held result stays and s_tready drops until
// it is taken.
// Reset empties the queue, zeroes the tag counter and clears m_tvalid;
// s_tready is low during reset.
module tagged_fifo_with_cancel_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // payload[31:0], send_handle[47:32], seed_key[63:48], dest_pe[79:64]
  input  logic [tfc_pkg::S_DATA_W-1:0]  s_tdata,
  // op[1:0]
  input  logic [tfc_pkg::OP_W-1:0]      s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // tag_out[15:0], payload_out[47:16], handle_out[63:48], pe_out[79:64],
  // load[84:80], zero pad [87:85]
  output logic [tfc_pkg::M_DATA_W-1:0]  m_tdata,
  // status[1:0]
  output logic [tfc_pkg::ST_W-1:0]      m_tuser
);
  import tfc_pkg::*;

  // Input fields.
  logic [PAY_W-1:0] payload;
  logic [HND_W-1:0] send_handle;
  logic [TAG_W-1:0] seed_key;
  logic [PE_W-1:0]  dest_pe;
  op_t              op;

  assign payload     = s_tdata[31:0];
  assign send_handle = s_tdata[47:32];
  assign seed_key    = s_tdata[63:48];
  assign dest_pe     = s_tdata[79:64];
  assign op          = op_t'(s_tuser);

  // Control state.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [TAG_W-1:0] next_tag;
  logic [TAG_W-1:0] next_tag_next;

  logic in_acc;
  logic empty;
  logic full;
  logic found;

  cell_ctl_t ctl;

  // Cell row wiring.
  entry_t ents [DEPTH];
  entry_t sels [DEPTH+1];
  logic   hits [DEPTH+1];

  // Result values.
  status_t          res_status;
  logic [TAG_W-1:0] res_tag;
  logic [PAY_W-1:0] res_payload;
  logic [HND_W-1:0] res_handle;
  logic [PE_W-1:0]  res_pe;

  // Output register.
  status_t           out_status;
  logic [TAG_W-1:0]  out_tag;
  logic [PAY_W-1:0]  out_payload;
  logic [HND_W-1:0]  out_handle;
  logic [PE_W-1:0]   out_pe;
  logic [LOAD_W-1:0] out_load;

  // Handshake: take an item whenever the result register can be refilled.
  assign s_tready = ~rst & (~m_tvalid | m_tready);
  assign in_acc   = s_tvalid & s_tready;

  assign empty = count == '0;
  assign full  = count == CNT_W'(DEPTH);
  assign found = hits[DEPTH];

  // Broadcast control to the cells.
  always_comb begin
    ctl.add_en    = in_acc && (op == OP_ADD) && !full;
    ctl.pick_en   = in_acc && (op == OP_PICK) && !empty;
    ctl.rm_en     = in_acc && (op == OP_REMOVE);
    ctl.count     = count;
    ctl.key       = seed_key;
    ctl.new_entry = '{tag: next_tag, payload: payload, handle: send_handle};
  end

  assign hits[0] = 1'b0;
  assign sels[0] = '0;

  // The row of cells; cell 0 holds the oldest entry.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t upper;
    if (i == DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid
      assign upper = ents[i+1];
    end

    tfc_cell u_cell (
      .clk     (clk),
      .idx     (IDX_W'(i)),
      .ctl     (ctl),
      .upper   (upper),
      .hit_in  (hits[i]),
      .sel_in  (sels[i]),
      .ent     (ents[i]),
      .hit_out (hits[i+1]),
      .sel_out (sels[i+1])
    );
  end

  // Result and next count for the current item.
  always_comb begin
    res_status    = ST_OK;
    res_tag       = '0;
    res_payload   = '0;
    res_handle    = '0;
    res_pe        = '0;
    count_next    = count;
    next_tag_next = next_tag;
    case (op)
      OP_ADD: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          res_tag       = next_tag;
          count_next    = count + CNT_W'(1);
          next_tag_next = next_tag + TAG_W'(1);
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else if (found) begin
          res_tag     = sels[DEPTH].tag;
          res_payload = sels[DEPTH].payload;
          res_handle  = sels[DEPTH].handle;
          count_next  = count - CNT_W'(1);
        end else begin
          res_status = ST_NOT_FOUND;
          res_tag    = seed_key;
        end
      end
      OP_PICK: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_tag     = ents[0].tag;
          res_payload = ents[0].payload;
          res_handle  = ents[0].handle;
          res_pe      = dest_pe;
          count_next  = count - CNT_W'(1);
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // Queue control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      next_tag <= '0;
    end else if (in_acc) begin
      count    <= count_next;
      next_tag <= next_tag_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_acc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_status  <= res_status;
      out_tag     <= res_tag;
      out_payload <= res_payload;
      out_handle  <= res_handle;
      out_pe      <= res_pe;
      out_load    <= LOAD_W'(count_next);
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {3'b000, out_load, out_pe, out_handle, out_payload, out_tag};

  // The fill count never passes the queue size.
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue count above capacity");

  // An add on a full queue reports full and leaves the queue and tag alone.
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && op == OP_ADD && full) |=>
      (m_tvalid && m_tuser == ST_FULL && $stable(count) && $stable(next_tag)))
    else $error("add on full queue changed state");

  // A remove that hits shrinks the queue by exactly one.
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && op == OP_REMOVE && !empty && found) |=>
      (count == $past(count) - CNT_W'(1) && m_tuser == ST_OK))
    else $error("remove hit did not close up the queue");

  // A remove on a nonempty queue that misses keeps the count.
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && op == OP_REMOVE && !empty && !found) |=>
      ($stable(count) && m_tuser == ST_NOT_FOUND))
    else $error("remove miss changed the queue");

endmodule

>>> rtl/tfc_cell.sv
module tfc_cell (
  input  logic                   clk,
  input  logic [tfc_pkg::IDX_W-1:0] idx,
  input  tfc_pkg::cell_ctl_t     ctl,
  input  tfc_pkg::entry_t        upper,
  input  logic                   hit_in,
  input  tfc_pkg::entry_t        sel_in,
  output tfc_pkg::entry_t        ent,
  output logic                   hit_out,
  output tfc_pkg::entry_t        sel_out
);
  import tfc_pkg::*;

  logic valid;
  logic match;
  logic first;
  logic at_tail;

  // Occupancy follows from the position against the fill count.
  assign valid   = CNT_W'(idx) < ctl.count;
  assign at_tail = CNT_W'(idx) == ctl.count;
  assign match   = valid && (ent.tag == ctl.key);

  // Hit chain: a cell sees whether it or any older cell matched.
  assign hit_out = hit_in | match;
  assign first   = match & ~hit_in;
  assign sel_out = first ? ent : sel_in;

  // Entry register: close up behind a removal, or take a new item at the tail.
  always_ff @(posedge clk) begin
    if (ctl.pick_en && valid) begin
      ent <= upper;
    end else if (ctl.rm_en && hit_out) begin
      ent <= upper;
    end else if (ctl.add_en && at_tail) begin
      ent <= ctl.new_entry;
    end
  end

endmodule
